[hdl/clhd_pkg.sv]
// shared types, codes and header strings for the content-length deframer
`default_nettype none

package clhd_pkg;

   typedef enum logic [6:0] {
      PH_KEY   = 7'b0000001,
      PH_LVAL  = 7'b0000010,
      PH_LTAIL = 7'b0000100,
      PH_TVAL  = 7'b0001000,
      PH_OTHER = 7'b0010000,
      PH_CR    = 7'b0100000,
      PH_BODY  = 7'b1000000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BODY  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_DELIMITER = 3'd1,
      ERR_TYPE      = 3'd2,
      ERR_KEY       = 3'd3,
      ERR_NO_LENGTH = 3'd4,
      ERR_LENGTH    = 3'd5
   } error_type;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int KEY_LEN_SIZE    = 14;
   localparam int KEY_TYPE_SIZE   = 12;
   localparam int TYPE_VALUE_SIZE = 40;

   localparam logic [8*KEY_LEN_SIZE-1:0]    KEY_LEN_TEXT  = "Content-Length";
   localparam logic [8*KEY_TYPE_SIZE-1:0]   KEY_TYPE_TEXT = "Content-Type";
   localparam logic [8*TYPE_VALUE_SIZE-1:0] TYPE_VALUE_TEXT =
      {"application/vs", "code-jsonrpc;charset=utf-8"};

   // position 63 is the saturated match position
   localparam logic [5:0] POS_MAX = 6'd63;

   function automatic logic len_key_hit(input logic [5:0] pos, input logic [7:0] b);
      logic hit;
      hit = 1'b0;
      if (pos < 6'(KEY_LEN_SIZE)) begin
         hit = (KEY_LEN_TEXT[8*(KEY_LEN_SIZE-1-int'(pos)) +: 8] == b);
      end
      return hit;
   endfunction

   function automatic logic type_key_hit(input logic [5:0] pos, input logic [7:0] b);
      logic hit;
      hit = 1'b0;
      if (pos < 6'(KEY_TYPE_SIZE)) begin
         hit = (KEY_TYPE_TEXT[8*(KEY_TYPE_SIZE-1-int'(pos)) +: 8] == b);
      end
      return hit;
   endfunction

   function automatic logic type_value_hit(input logic [5:0] pos, input logic [7:0] b);
      logic hit;
      hit = 1'b0;
      if (pos < 6'(TYPE_VALUE_SIZE)) begin
         hit = (TYPE_VALUE_TEXT[8*(TYPE_VALUE_SIZE-1-int'(pos)) +: 8] == b);
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

[hdl/content_length_header_deframer_top.sv]
// content-length header deframer: header line parser and body byte passer
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_ready   req_in_byte
//   rsp       out         rsp_valid/rsp_ready   rsp_kind, rsp_body_byte, rsp_last,
//                                               rsp_error_code
//
// one byte per cycle while req_ready is high: the parser state and any result are
// registered at the same edge that takes a request, the result into the single output register
// req_ready is low during reset and while that output register holds a result not yet taken
// header bytes and line ends give no result unless they close an error or an empty message
// synchronous active-high reset returns the parser to header start
`default_nettype none

module content_length_header_deframer_top #(
   parameter int LENGTH_BITS = 24
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_body_byte,
   output logic            rsp_last,
   output logic [2:0]      rsp_error_code
);

   localparam int PROD_BITS = LENGTH_BITS + 4;

   clhd_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic                   has_bytes_ff, has_bytes_in, cur_has_bytes;
   logic [5:0]             pos_ff, pos_in, cur_pos;
   logic [1:0]             cand_ff, cand_in, cur_cand;
   logic                   value_ok_ff, value_ok_in, cur_value_ok;
   logic                   digits_ff, digits_in, cur_digits;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic                   found_ff, found_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [7:0]             rsp_body_byte_ff, rsp_body_byte_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [2:0]             rsp_error_code_ff, rsp_error_code_in;

   logic                   accept;
   logic                   emit;
   logic [7:0]             b;
   logic [PROD_BITS-1:0]   acc_next;
   logic                   is_digit;
   logic                   is_blank;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign b         = req_in_byte;

   assign is_digit = (b >= clhd_pkg::CHAR_ZERO) && (b <= clhd_pkg::CHAR_NINE);
   assign is_blank = (b == clhd_pkg::CHAR_SPACE) || (b == clhd_pkg::CHAR_TAB);
   // acc * 10 + digit as shift-add
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                     + PROD_BITS'(b[3:0]);

   // line registers as the line parser sees them; stray phase codes start a new line
   always_comb begin
      case (phase_ff)
         clhd_pkg::PH_KEY, clhd_pkg::PH_LVAL, clhd_pkg::PH_LTAIL,
         clhd_pkg::PH_TVAL, clhd_pkg::PH_OTHER: begin
            cur_phase     = phase_ff;
            cur_has_bytes = has_bytes_ff;
            cur_pos       = pos_ff;
            cur_cand      = cand_ff;
            cur_value_ok  = value_ok_ff;
            cur_digits    = digits_ff;
         end
         default: begin
            cur_phase     = clhd_pkg::PH_KEY;
            cur_has_bytes = 1'b0;
            cur_pos       = '0;
            cur_cand      = 2'b11;
            cur_value_ok  = 1'b1;
            cur_digits    = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in          = phase_ff;
      has_bytes_in      = has_bytes_ff;
      pos_in            = pos_ff;
      cand_in           = cand_ff;
      value_ok_in       = value_ok_ff;
      digits_in         = digits_ff;
      acc_in            = acc_ff;
      found_in          = found_ff;
      remain_in         = remain_ff;
      emit              = 1'b0;
      rsp_kind_in       = clhd_pkg::KIND_BODY;
      rsp_body_byte_in  = '0;
      rsp_last_in       = 1'b0;
      rsp_error_code_in = clhd_pkg::ERR_NONE;

      if (accept) begin
         case (phase_ff)
            clhd_pkg::PH_BODY: begin
               emit             = 1'b1;
               rsp_kind_in      = clhd_pkg::KIND_BODY;
               rsp_body_byte_in = b;
               rsp_last_in      = (remain_ff <= LENGTH_BITS'(1));
               if (remain_ff <= LENGTH_BITS'(1)) begin
                  phase_in     = clhd_pkg::PH_KEY;
                  has_bytes_in = 1'b0;
                  pos_in       = '0;
                  cand_in      = 2'b11;
                  value_ok_in  = 1'b1;
                  digits_in    = 1'b0;
                  acc_in       = '0;
                  found_in     = 1'b0;
                  remain_in    = '0;
               end else begin
                  remain_in = remain_ff - LENGTH_BITS'(1);
               end
            end

            clhd_pkg::PH_CR: begin
               // header start unless the line just ended cleanly or a body follows
               phase_in     = clhd_pkg::PH_KEY;
               has_bytes_in = 1'b0;
               pos_in       = '0;
               cand_in      = 2'b11;
               value_ok_in  = 1'b1;
               digits_in    = 1'b0;
               if (b != clhd_pkg::CHAR_LF) begin
                  emit              = 1'b1;
                  rsp_kind_in       = clhd_pkg::KIND_ERROR;
                  rsp_error_code_in = clhd_pkg::ERR_DELIMITER;
                  acc_in            = '0;
                  found_in          = 1'b0;
                  remain_in         = '0;
               end else if (has_bytes_ff) begin
                  if (pos_ff != '0) begin
                     emit              = 1'b1;
                     rsp_kind_in       = clhd_pkg::KIND_ERROR;
                     rsp_error_code_in = pos_ff[2:0];
                     acc_in            = '0;
                     found_in          = 1'b0;
                     remain_in         = '0;
                  end
               end else if (!found_ff) begin
                  emit              = 1'b1;
                  rsp_kind_in       = clhd_pkg::KIND_ERROR;
                  rsp_error_code_in = clhd_pkg::ERR_NO_LENGTH;
                  acc_in            = '0;
                  remain_in         = '0;
               end else if (acc_ff == '0) begin
                  emit        = 1'b1;
                  rsp_kind_in = clhd_pkg::KIND_EMPTY;
                  rsp_last_in = 1'b1;
                  found_in    = 1'b0;
                  remain_in   = '0;
               end else begin
                  remain_in = acc_ff;
                  phase_in  = clhd_pkg::PH_BODY;
               end
            end

            default: begin
               phase_in     = cur_phase;
               has_bytes_in = 1'b1;
               pos_in       = cur_pos;
               cand_in      = cur_cand;
               value_ok_in  = cur_value_ok;
               digits_in    = cur_digits;
               if (b == clhd_pkg::CHAR_CR) begin
                  // line verdict parks in the match position until the lf
                  has_bytes_in = cur_has_bytes;
                  phase_in     = clhd_pkg::PH_CR;
                  case (cur_phase)
                     clhd_pkg::PH_KEY: begin
                        pos_in = cur_has_bytes ? 6'(clhd_pkg::ERR_KEY)
                                               : 6'(clhd_pkg::ERR_NONE);
                     end
                     clhd_pkg::PH_LVAL, clhd_pkg::PH_LTAIL: begin
                        if (!cur_digits || !cur_value_ok) begin
                           pos_in = 6'(clhd_pkg::ERR_LENGTH);
                        end else begin
                           pos_in   = 6'(clhd_pkg::ERR_NONE);
                           found_in = 1'b1;
                        end
                     end
                     clhd_pkg::PH_TVAL: begin
                        pos_in = (cur_value_ok && cur_pos == 6'(clhd_pkg::TYPE_VALUE_SIZE))
                                 ? 6'(clhd_pkg::ERR_NONE) : 6'(clhd_pkg::ERR_TYPE);
                     end
                     default: begin
                        pos_in = 6'(clhd_pkg::ERR_KEY);
                     end
                  endcase
               end else begin
                  case (cur_phase)
                     clhd_pkg::PH_KEY: begin
                        if (b == clhd_pkg::CHAR_COLON) begin
                           pos_in = '0;
                           if (cur_cand[0] && cur_pos == 6'(clhd_pkg::KEY_LEN_SIZE)) begin
                              phase_in    = clhd_pkg::PH_LVAL;
                              acc_in      = '0;
                              digits_in   = 1'b0;
                              value_ok_in = 1'b1;
                           end else if (cur_cand[1] &&
                                        cur_pos == 6'(clhd_pkg::KEY_TYPE_SIZE)) begin
                              phase_in    = clhd_pkg::PH_TVAL;
                              value_ok_in = 1'b1;
                           end else begin
                              phase_in = clhd_pkg::PH_OTHER;
                           end
                        end else begin
                           cand_in[0] = cur_cand[0] && clhd_pkg::len_key_hit(cur_pos, b);
                           cand_in[1] = cur_cand[1] && clhd_pkg::type_key_hit(cur_pos, b);
                           if (cur_pos < clhd_pkg::POS_MAX) begin
                              pos_in = cur_pos + 6'd1;
                           end
                        end
                     end
                     clhd_pkg::PH_LVAL: begin
                        if (is_digit) begin
                           digits_in = 1'b1;
                           if (cur_value_ok) begin
                              if (acc_next[PROD_BITS-1:LENGTH_BITS] != '0) begin
                                 value_ok_in = 1'b0;
                              end else begin
                                 acc_in = acc_next[LENGTH_BITS-1:0];
                              end
                           end
                        end else if (cur_digits || !is_blank) begin
                           phase_in = clhd_pkg::PH_LTAIL;
                        end
                     end
                     clhd_pkg::PH_TVAL: begin
                        value_ok_in = cur_value_ok && clhd_pkg::type_value_hit(cur_pos, b);
                        if (cur_pos < clhd_pkg::POS_MAX) begin
                           pos_in = cur_pos + 6'd1;
                        end
                     end
                     default: begin
                        pos_in = cur_pos;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= clhd_pkg::PH_KEY;
         has_bytes_ff <= 1'b0;
         pos_ff       <= '0;
         cand_ff      <= 2'b11;
         value_ok_ff  <= 1'b1;
         digits_ff    <= 1'b0;
         acc_ff       <= '0;
         found_ff     <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         has_bytes_ff <= has_bytes_in;
         pos_ff       <= pos_in;
         cand_ff      <= cand_in;
         value_ok_ff  <= value_ok_in;
         digits_ff    <= digits_in;
         acc_ff       <= acc_in;
         found_ff     <= found_in;
         remain_ff    <= remain_in;
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= accept && emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff       <= rsp_kind_in;
         rsp_body_byte_ff  <= rsp_body_byte_in;
         rsp_last_ff       <= rsp_last_in;
         rsp_error_code_ff <= rsp_error_code_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_body_byte  = rsp_body_byte_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_error_code = rsp_error_code_ff;

endmodule

`default_nettype wire

[hdl/clhd_checker.sv]
// port-level checker for the content-length deframer and its bind
`default_nettype none

module clhd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_in_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_body_byte,
   input wire logic       rsp_last,
   input wire logic [2:0] rsp_error_code
);

   // a result not yet taken holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_body_byte) && $stable(rsp_last) && $stable(rsp_error_code))
      else $error("rsp payload changed while stalled");

   // error results carry a code and nothing else
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == clhd_pkg::KIND_ERROR |->
         rsp_error_code != clhd_pkg::ERR_NONE && rsp_body_byte == 8'h00 && !rsp_last)
      else $error("malformed error result");

   // empty message is always last with no data
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == clhd_pkg::KIND_EMPTY |->
         rsp_last && rsp_body_byte == 8'h00 && rsp_error_code == clhd_pkg::ERR_NONE)
      else $error("malformed empty-message result");

   // a free output slot means a request can be taken
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled with free output slot");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind content_length_header_deframer_top clhd_checker u_clhd_checker (.*);

`default_nettype wire

[bench/clhd_deframe_checker.sv]
// checker for the content-length deframer: predicts each result and compares it
`timescale 1ns / 100ps

module clhd_deframe_checker
   import clhd_pkg::*;
#(
   parameter int LENGTH_BITS = 24
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [1:0] rsp_kind,
   input  wire logic [7:0] rsp_body_byte,
   input  wire logic       rsp_last,
   input  wire logic [2:0] rsp_error_code,
   output int              fail_count,
   output int              pending_count
);

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
      error_type  code;
   } deframe_out_type;

   localparam logic [LENGTH_BITS-1:0] LEN_LIMIT = '1;

   phase_type              ph;
   logic                   line_seen;
   logic [5:0]             pos;
   logic [1:0]             keys_live;   // bit 0 length key, bit 1 type key
   logic                   value_good;
   logic                   got_digit;
   logic [LENGTH_BITS-1:0] length_sum;
   logic                   length_known;
   logic [LENGTH_BITS-1:0] body_left;

   deframe_out_type awaited[$];
   int              mismatches = 0;

   function automatic logic text_hit(input logic [319:0] text, input int size,
                                     input logic [5:0] at, input logic [7:0] b);
      logic hit;
      hit = 1'b0;
      if (int'(at) < size) begin
         hit = (8'(text >> (8 * (size - 1 - int'(at)))) == b);
      end
      return hit;
   endfunction

   function void new_line();
      ph         = PH_KEY;
      line_seen  = 1'b0;
      pos        = '0;
      keys_live  = 2'b11;
      value_good = 1'b1;
      got_digit  = 1'b0;
   endfunction

   function void header_start();
      new_line();
      length_sum   = '0;
      length_known = 1'b0;
      body_left    = '0;
   endfunction

   task automatic parse_byte(input logic [7:0] b, output bit got,
                             output deframe_out_type res);
      error_type              err;
      logic [LENGTH_BITS+4:0] sum;
      err = ERR_NONE;
      got = 1'b0;
      res = '{kind: KIND_BODY, data: 8'h00, last: 1'b0, code: ERR_NONE};
      if (ph == PH_BODY) begin
         got      = 1'b1;
         res.data = b;
         res.last = (body_left <= 1);
         if (res.last) begin
            header_start();
         end else begin
            body_left = body_left - 1'b1;
         end
      end else if (ph == PH_CR) begin
         if (b != CHAR_LF) begin
            err = ERR_DELIMITER;
         end else if (line_seen) begin
            if (pos[2:0] != 3'(ERR_NONE)) begin
               err = error_type'(pos[2:0]);
            end else begin
               new_line();
            end
         end else if (!length_known) begin
            err = ERR_NO_LENGTH;
         end else if (length_sum == '0) begin
            header_start();
            got      = 1'b1;
            res.kind = KIND_EMPTY;
            res.last = 1'b1;
         end else begin
            body_left = length_sum;
            ph        = PH_BODY;
         end
      end else if (b == CHAR_CR) begin
         // verdict of the finished line waits in pos until the lf
         case (ph)
            PH_KEY: pos = line_seen ? 6'(ERR_KEY) : 6'(ERR_NONE);
            PH_LVAL, PH_LTAIL: begin
               if (got_digit && value_good) begin
                  length_known = 1'b1;
                  pos          = 6'(ERR_NONE);
               end else begin
                  pos = 6'(ERR_LENGTH);
               end
            end
            PH_TVAL: begin
               pos = (value_good && pos == 6'(TYPE_VALUE_SIZE)) ? 6'(ERR_NONE) : 6'(ERR_TYPE);
            end
            default: pos = 6'(ERR_KEY);
         endcase
         ph = PH_CR;
      end else begin
         case (ph)
            PH_KEY: begin
               if (b == CHAR_COLON) begin
                  if (keys_live[0] && pos == 6'(KEY_LEN_SIZE)) begin
                     ph         = PH_LVAL;
                     length_sum = '0;
                     got_digit  = 1'b0;
                     value_good = 1'b1;
                  end else if (keys_live[1] && pos == 6'(KEY_TYPE_SIZE)) begin
                     ph         = PH_TVAL;
                     value_good = 1'b1;
                  end else begin
                     ph = PH_OTHER;
                  end
                  pos = '0;
               end else begin
                  if (!text_hit(KEY_LEN_TEXT, KEY_LEN_SIZE, pos, b)) keys_live[0] = 1'b0;
                  if (!text_hit(KEY_TYPE_TEXT, KEY_TYPE_SIZE, pos, b)) keys_live[1] = 1'b0;
                  if (pos != POS_MAX) pos++;
               end
            end
            PH_LVAL: begin
               if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                  got_digit = 1'b1;
                  if (value_good) begin
                     sum = (LENGTH_BITS+5)'(length_sum * 10 + (b - CHAR_ZERO));
                     if (sum > LEN_LIMIT) begin
                        value_good = 1'b0;
                     end else begin
                        length_sum = sum[LENGTH_BITS-1:0];
                     end
                  end
               end else if (got_digit || (b != CHAR_SPACE && b != CHAR_TAB)) begin
                  ph = PH_LTAIL;
               end
            end
            PH_TVAL: begin
               if (!text_hit(TYPE_VALUE_TEXT, TYPE_VALUE_SIZE, pos, b)) value_good = 1'b0;
               if (pos != POS_MAX) pos++;
            end
            default: ;
         endcase
         line_seen = 1'b1;
      end
      if (err != ERR_NONE) begin
         header_start();
         got      = 1'b1;
         res.kind = KIND_ERROR;
         res.code = err;
      end
   endtask

   always @(posedge clock) begin
      deframe_out_type want;
      deframe_out_type made;
      bit              got;
      if (reset) begin
         header_start();
         awaited.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: rsp with nothing awaited: kind %0d byte %02h last %0d code %0d",
                           $time, rsp_kind, rsp_body_byte, rsp_last, rsp_error_code);
               end
            end else begin
               want = awaited.pop_front();
               if (rsp_kind !== want.kind || rsp_body_byte !== want.data ||
                   rsp_last !== want.last || rsp_error_code !== want.code) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: rsp mismatch: expected kind %0d byte %02h last %0d code %0d",
                              $time, want.kind, want.data, want.last, want.code);
                     $display("%0t:               got kind %0d byte %02h last %0d code %0d",
                              $time, rsp_kind, rsp_body_byte, rsp_last, rsp_error_code);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_in_byte, got, made);
            if (got) awaited.insert(awaited.size(), made);
         end
      end
      fail_count    <= mismatches;
      pending_count <= awaited.size();
   end

endmodule

[bench/tb_content_length_header_deframer_top.sv]
// testbench top for the content-length deframer: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_content_length_header_deframer_top;
   import clhd_pkg::*;

   localparam int LENGTH_BITS    = 24;
   localparam int ITEM_COUNT     = 650;
   localparam int WATCHDOG_LIMIT = 1000;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_body_byte;
   logic       rsp_last;
   logic [2:0] rsp_error_code;
   int         fail_count;
   int         pending_count;
   int         idle_cycles = 0;
   int         bytes_sent  = 0;
   logic [7:0] stream[$];

   content_length_header_deframer_top #(
      .LENGTH_BITS(LENGTH_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_body_byte (rsp_body_byte),
      .rsp_last      (rsp_last),
      .rsp_error_code(rsp_error_code)
   );

   clhd_deframe_checker #(
      .LENGTH_BITS(LENGTH_BITS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_body_byte (rsp_body_byte),
      .rsp_last      (rsp_last),
      .rsp_error_code(rsp_error_code),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 88) return int'($urandom_range(1, 3));
      if (pick < 98) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   task automatic add_byte(input logic [7:0] b);
      stream.insert(stream.size(), b);
   endtask

   task automatic push_text(input logic [319:0] text, input int size);
      for (int i = size - 1; i >= 0; i--) add_byte(text[8*i +: 8]);
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic push_crlf();
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
   endtask

   task automatic push_length_line(input longint unsigned v);
      push_text(KEY_LEN_TEXT, KEY_LEN_SIZE);
      push_str($sformatf(": %0d", v));
      push_crlf();
   endtask

   task automatic push_type_line();
      push_text(KEY_TYPE_TEXT, KEY_TYPE_SIZE);
      add_byte(CHAR_COLON);
      push_text(TYPE_VALUE_TEXT, TYPE_VALUE_SIZE);
      push_crlf();
   endtask

   task automatic push_body(input int n);
      repeat (n) add_byte(8'($urandom));
   endtask

   // random line text with no cr in it
   task automatic push_junk(input int n);
      logic [7:0] b;
      repeat (n) begin
         b = 8'($urandom);
         add_byte(b == CHAR_CR ? CHAR_LF : b);
      end
   endtask

   task automatic send_stream();
      logic [7:0] b;
      int         gap;
      bit         steady;
      steady = ($urandom_range(0, 3) == 0);
      while (stream.size() > 0) begin
         b   = stream.pop_front();
         gap = steady ? 0 : gap_len();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_in_byte <= b;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         bytes_sent++;
      end
   endtask

   // hold off until every predicted result has been taken
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic build_random_message();
      int         pick;
      int         len;
      int         n;
      int         ix;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         // well-formed header and body
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
         if ($urandom_range(0, 1)) push_type_line();
         if ($urandom_range(0, 4) == 0) push_length_line($urandom_range(0, 99999));
         push_text(KEY_LEN_TEXT, KEY_LEN_SIZE);
         add_byte(CHAR_COLON);
         repeat ($urandom_range(0, 3)) add_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
         repeat ($urandom_range(0, 2)) add_byte(CHAR_ZERO);
         push_str($sformatf("%0d", len));
         if ($urandom_range(0, 3) == 0) push_junk($urandom_range(1, 6));
         push_crlf();
         if ($urandom_range(0, 3) == 0) push_type_line();
         push_crlf();
         push_body(len);
      end else if (pick < 68) begin
         // content type off by one character, cut short or too long
         push_text(KEY_TYPE_TEXT, KEY_TYPE_SIZE);
         add_byte(CHAR_COLON);
         n = stream.size();
         push_text(TYPE_VALUE_TEXT, TYPE_VALUE_SIZE);
         case ($urandom_range(0, 2))
            0: begin
               ix = n + $urandom_range(0, TYPE_VALUE_SIZE - 1);
               stream[ix] = stream[ix] ^ 8'($urandom_range(1, 255));
            end
            1: repeat ($urandom_range(1, 5)) void'(stream.pop_back());
            default: push_junk($urandom_range(1, 4));
         endcase
         push_crlf();
      end else if (pick < 76) begin
         // unknown key, near miss of a known key, or no colon
         case ($urandom_range(0, 2))
            0: repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(97, 122)));
            1: begin
               push_text(KEY_LEN_TEXT, KEY_LEN_SIZE);
               void'(stream.pop_back());
            end
            default: begin
               push_text(KEY_TYPE_TEXT, KEY_TYPE_SIZE);
               push_str("s");
            end
         endcase
         if ($urandom_range(0, 3) != 0) add_byte(CHAR_COLON);
         push_junk($urandom_range(0, 8));
         push_crlf();
      end else if (pick < 82) begin
         push_text(KEY_LEN_TEXT, KEY_LEN_SIZE);
         add_byte(CHAR_COLON);
         add_byte(CHAR_SPACE);
         case ($urandom_range(0, 2))
            0: push_str($sformatf("%0d", (64'd1 << LENGTH_BITS) + $urandom_range(0, 1000000)));
            1: push_str($sformatf("%0d%0d", $urandom_range(100, 999), $urandom_range(0, 999999)));
            default: push_str("none");
         endcase
         push_crlf();
      end else if (pick < 86) begin
         // empty line with no length seen
         if ($urandom_range(0, 1)) push_type_line();
         push_crlf();
      end else if (pick < 92) begin
         // cr followed by something other than lf
         if ($urandom_range(0, 1)) push_type_line();
         push_junk($urandom_range(0, 6));
         add_byte(CHAR_CR);
         b = 8'($urandom);
         add_byte(b == CHAR_LF ? CHAR_CR : b);
      end else begin
         push_body($urandom_range(3, 20));
         push_crlf();
      end
   endtask

   initial begin : rsp_side
      int hold;
      int quiet;
      hold  = 0;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (quiet > 0) begin
            quiet--;
            rsp_ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 3) begin
               quiet = $urandom_range(50, 200);
            end else if ($urandom_range(0, 99) < 30) begin
               hold = gap_len();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // body with extreme bytes, then an empty body
      push_length_line(3);
      push_crlf();
      add_byte(8'h00);
      add_byte(8'hff);
      add_byte(CHAR_CR);
      push_length_line(0);
      push_crlf();
      // blanks, leading zeros and trailing text after the digits
      push_type_line();
      push_text(KEY_LEN_TEXT, KEY_LEN_SIZE);
      add_byte(CHAR_COLON);
      add_byte(CHAR_TAB);
      push_str(" 0001 2;x");
      add_byte(CHAR_LF);
      push_crlf();
      push_crlf();
      add_byte(CHAR_LF);
      // cr without lf, the byte after it is dropped
      add_byte(CHAR_CR);
      push_str("x");
      add_byte(CHAR_CR);
      add_byte(CHAR_CR);
      // largest length, then overridden by a later one; body is cr lf
      push_length_line((64'd1 << LENGTH_BITS) - 1);
      push_length_line(2);
      push_crlf();
      push_crlf();
      // length too large, length with no digits
      push_length_line(64'd1 << LENGTH_BITS);
      push_text(KEY_LEN_TEXT, KEY_LEN_SIZE);
      add_byte(CHAR_COLON);
      push_crlf();
      // content type wrong in its last character, and one character too long
      push_text(KEY_TYPE_TEXT, KEY_TYPE_SIZE);
      add_byte(CHAR_COLON);
      push_text(TYPE_VALUE_TEXT >> 8, TYPE_VALUE_SIZE - 1);
      push_str("9");
      push_crlf();
      push_text(KEY_TYPE_TEXT, KEY_TYPE_SIZE);
      add_byte(CHAR_COLON);
      push_text(TYPE_VALUE_TEXT, TYPE_VALUE_SIZE);
      push_str("x");
      push_crlf();
      // unknown keys, a line without colon, a bare lf inside a line
      push_str("X-Custom: 1");
      push_crlf();
      push_str("no colon here");
      push_crlf();
      push_str("a");
      add_byte(CHAR_LF);
      push_str("b:");
      push_crlf();
      push_text(KEY_LEN_TEXT, KEY_LEN_SIZE);
      push_str("x: 5");
      push_crlf();
      push_str("content-length: 5");
      push_crlf();
      // empty line before any length
      push_crlf();
      push_type_line();
      push_crlf();
      send_stream();
      drain();

      while (bytes_sent < ITEM_COUNT) begin
         build_random_message();
         send_stream();
         if ($urandom_range(0, 14) == 0) drain();
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
